// File: hdl/clx_pkg.sv
package clx_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Display instruction and character codes
  localparam logic [3:0] INIT_NIBBLE = 4'h2;
  localparam logic [7:0] FUNC_SET    = 8'h28;
  localparam logic [7:0] DISP_ON     = 8'h0C;
  localparam logic [7:0] ENTRY_MODE  = 8'h06;
  localparam logic [7:0] SHIFT_CMD   = 8'h11;
  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [7:0] ROW_OFFSET  = 8'h40;
  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] BACKSLASH   = 8'h5C;
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam logic [7:0] NUL_CHAR    = 8'h00;
  localparam logic [7:0] ENABLE_BIT  = 8'h04;

  // Transfers kept per item; the rest are dropped
  localparam int MAX_RESULTS = 49;
  // Entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified command from the front
  typedef enum logic [2:0] {
    OP_NOP,
    OP_BEGIN,
    OP_CHAR,
    OP_PAD_ROW,
    OP_PAD_END
  } clx_op_t;

  typedef struct packed {
    clx_op_t    op;
    logic [7:0] char_code;
  } clx_cmd_t;

  // Back sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_INIT_NIB,
    B_INIT_FUNC,
    B_DISP,
    B_ENTRY,
    B_SHIFT,
    B_HOME,
    B_CHAR,
    B_PAD,
    B_ROW_CURSOR
  } clx_bst_t;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic powered_up;
    logic frame_done;
    logic row;
  } clx_stat_t;

  // Expander byte with enable low: nibble, backlight, register select
  function automatic logic [7:0] bus_base(input logic [3:0] nib, input logic led,
                                          input logic rs);
    bus_base = {nib, led, 2'b00, rs};
  endfunction

endpackage

// File: hdl/clx_if.sv
interface clx_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface clx_xfer_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic       two_nibbles;
  logic [3:0] first_nibble;
  logic [3:0] second_nibble;
  logic [7:0] bus_byte_a;
  logic [7:0] bus_byte_b;
  logic [7:0] bus_byte_c;
  logic [7:0] bus_byte_d;
  logic [7:0] bus_byte_e;
  logic [7:0] bus_byte_f;
  logic       last;

  modport source (output valid, output is_data, output two_nibbles, output first_nibble,
                  output second_nibble, output bus_byte_a, output bus_byte_b,
                  output bus_byte_c, output bus_byte_d, output bus_byte_e,
                  output bus_byte_f, output last, input ready);
  modport sink   (input valid, input is_data, input two_nibbles, input first_nibble,
                  input second_nibble, input bus_byte_a, input bus_byte_b,
                  input bus_byte_c, input bus_byte_d, input bus_byte_e,
                  input bus_byte_f, input last, output ready);
endinterface

// File: hdl/clx_front.sv
module clx_front
  import clx_pkg::*;
(
  clx_cmd_if.sink  cmd,
  input  logic     full,
  output logic     push,
  output clx_cmd_t push_cmd
);

  // Take an item whenever the queue has room
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  // Classify the item into a back-end command
  always_comb begin
    push_cmd.char_code = cmd.char_code;
    unique case (cmd.kind)
      KIND_BEGIN: push_cmd.op = OP_BEGIN;
      KIND_BYTE: begin
        if (cmd.char_code inside {BACKSLASH, NEWLINE, NUL_CHAR}) begin
          push_cmd.op = OP_PAD_ROW;
        end else begin
          push_cmd.op = OP_CHAR;
        end
      end
      KIND_END:   push_cmd.op = OP_PAD_END;
      default:    push_cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/clx_fifo.sv
module clx_fifo
  import clx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  clx_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output clx_cmd_t pop_data,
  output logic     empty
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  clx_cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/clx_back.sv
module clx_back
  import clx_pkg::*;
#(
  parameter int COLUMNS = 24,
  parameter int ROWS    = 2,
  parameter int ColW    = $clog2(COLUMNS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            backlight,
  input  logic            empty,
  input  clx_cmd_t        pop_data,
  output logic            pop,
  clx_xfer_if.source      xfer,
  output clx_stat_t       stat,
  output logic [ColW-1:0] col
);

  localparam int CntW = $clog2(MAX_RESULTS + 1);

  clx_bst_t        state;
  clx_bst_t        state_next;
  logic            powered_up;
  logic            frame_done;
  logic            row;
  logic            pad_all;
  logic [7:0]      ch;
  logic [CntW-1:0] count;
  logic            out_valid;

  logic [ColW:0]   col_plus;
  logic            at_end;
  logic            row_next_ok;
  logic            out_free;
  logic            room;
  logic            step;
  logic [7:0]      cursor_byte;

  logic            e_rs;
  logic            e_pair;
  logic [7:0]      e_val;
  logic            e_final;
  logic [3:0]      e_hi;
  logic [3:0]      e_lo;
  logic [7:0]      e_base_hi;
  logic [7:0]      e_base_lo;

  assign stat.powered_up = powered_up;
  assign stat.frame_done = frame_done;
  assign stat.row        = row;
  assign xfer.valid      = out_valid;

  // Cursor and step conditions
  assign col_plus    = (ColW + 1)'(col) + 1'b1;
  assign at_end      = (col_plus >= (ColW + 1)'(COLUMNS));
  assign row_next_ok = (ROWS > 1) && !row;
  assign cursor_byte = CURSOR_BASE + (row ? ROW_OFFSET : 8'h00) + 8'(col);
  assign out_free    = !out_valid || xfer.ready;
  assign room        = (count < CntW'(MAX_RESULTS));
  assign step        = (state != B_IDLE) && (!room || out_free);
  assign pop         = (state == B_IDLE) && !empty;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          unique case (pop_data.op)
            OP_BEGIN:   state_next = powered_up ? B_DISP : B_INIT_NIB;
            OP_CHAR:    state_next = frame_done ? B_IDLE : B_CHAR;
            OP_PAD_ROW,
            OP_PAD_END: state_next = frame_done ? B_IDLE : B_PAD;
            default:    state_next = B_IDLE;
          endcase
        end
      end
      B_INIT_NIB:  if (step) state_next = B_INIT_FUNC;
      B_INIT_FUNC: if (step) state_next = B_DISP;
      B_DISP:      if (step) state_next = B_ENTRY;
      B_ENTRY:     if (step) state_next = B_SHIFT;
      B_SHIFT:     if (step) state_next = B_HOME;
      B_HOME:      if (step) state_next = B_IDLE;
      B_CHAR: begin
        if (step) state_next = (at_end && row_next_ok) ? B_ROW_CURSOR : B_IDLE;
      end
      B_PAD: begin
        if (step && at_end) state_next = row_next_ok ? B_ROW_CURSOR : B_IDLE;
      end
      B_ROW_CURSOR: if (step) state_next = pad_all ? B_PAD : B_IDLE;
      default:      state_next = B_IDLE;
    endcase
  end

  // Transfer that the current state emits
  always_comb begin
    e_rs    = 1'b0;
    e_pair  = 1'b1;
    e_val   = 8'h00;
    e_final = 1'b0;
    unique case (state)
      B_INIT_NIB: begin
        e_pair = 1'b0;
        e_val  = {4'h0, INIT_NIBBLE};
      end
      B_INIT_FUNC: e_val = FUNC_SET;
      B_DISP:      e_val = DISP_ON;
      B_ENTRY:     e_val = ENTRY_MODE;
      B_SHIFT:     e_val = SHIFT_CMD;
      B_HOME: begin
        e_val   = cursor_byte;
        e_final = 1'b1;
      end
      B_CHAR: begin
        e_rs    = 1'b1;
        e_val   = ch;
        e_final = !(at_end && row_next_ok);
      end
      B_PAD: begin
        e_rs    = 1'b1;
        e_val   = SPACE_CHAR;
        e_final = at_end && !row_next_ok;
      end
      B_ROW_CURSOR: begin
        e_val   = cursor_byte;
        e_final = !pad_all;
      end
      default: e_pair = 1'b0;
    endcase
  end

  // Split into nibbles and expander bytes
  assign e_hi      = e_pair ? e_val[7:4] : e_val[3:0];
  assign e_lo      = e_pair ? e_val[3:0] : 4'h0;
  assign e_base_hi = bus_base(e_hi, backlight, e_rs);
  assign e_base_lo = bus_base(e_lo, backlight, e_rs);

  // Sequencer and display state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      powered_up <= 1'b0;
      frame_done <= 1'b1;
      row        <= 1'b0;
      col        <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        count <= '0;
        if (pop_data.op == OP_BEGIN) begin
          powered_up <= 1'b1;
          frame_done <= 1'b0;
          row        <= 1'b0;
          col        <= '0;
        end
      end
      // Advance the column after a letter or a space; wrap to the next row or close the frame
      if (step && (state == B_CHAR || state == B_PAD)) begin
        if (at_end && row_next_ok) begin
          row <= 1'b1;
          col <= '0;
        end else begin
          col <= col_plus[ColW-1:0];
          if (at_end) begin
            frame_done <= 1'b1;
          end
        end
      end
      if (step && room) begin
        count     <= count + 1'b1;
        out_valid <= 1'b1;
      end else if (xfer.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the command payload on pop
  always_ff @(posedge clk) begin
    if (pop) begin
      ch      <= pop_data.char_code;
      pad_all <= (pop_data.op == OP_PAD_END);
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (step && room) begin
      xfer.is_data       <= e_rs;
      xfer.two_nibbles   <= e_pair;
      xfer.first_nibble  <= e_hi;
      xfer.second_nibble <= e_lo;
      xfer.bus_byte_a    <= e_base_hi;
      xfer.bus_byte_b    <= e_base_hi | ENABLE_BIT;
      xfer.bus_byte_c    <= e_base_hi;
      xfer.bus_byte_d    <= e_pair ? e_base_lo : 8'h00;
      xfer.bus_byte_e    <= e_pair ? (e_base_lo | ENABLE_BIT) : 8'h00;
      xfer.bus_byte_f    <= e_pair ? e_base_lo : 8'h00;
      xfer.last          <= e_final || (count == CntW'(MAX_RESULTS - 1));
    end
  end

endmodule

// File: hdl/char_lcd_4bit_expander_sequencer_core.sv
// An item passes the queue and the sequencer state before its first transfer is registered.
// Throughput: the back sequencer sends one transfer per cycle while the output is taken,
// through the one output register, and goes back to idle before it takes the next item.
// A two-entry command queue lets new items be taken while the sequencer is busy.
// Reset (rst, synchronous, active high): backlight 1, no frame open, display not powered,
// so the next begin sends the power-up nibbles first.
module char_lcd_4bit_expander_sequencer_core
  import clx_pkg::*;
#(
  parameter int COLUMNS = 24,
  parameter int ROWS    = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  clx_cmd_if.sink    cmd,
  clx_xfer_if.source xfer
);

  localparam int ColW = $clog2(COLUMNS + 1);

  logic            backlight;
  logic            push;
  clx_cmd_t        push_cmd;
  logic            full;
  logic            pop;
  clx_cmd_t        pop_cmd;
  logic            empty;
  clx_stat_t       stat;
  logic [ColW-1:0] col;

  // Backlight register
  always_ff @(posedge clk) begin
    if (rst) begin
      backlight <= 1'b1;
    end else if (cfg_wr_en) begin
      backlight <= cfg_wr_data;
    end
  end

  clx_front u_front (
    .cmd      (cmd),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  clx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .empty     (empty)
  );

  clx_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ColW    (ColW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .backlight (backlight),
    .empty     (empty),
    .pop_data  (pop_cmd),
    .pop       (pop),
    .xfer      (xfer),
    .stat      (stat),
    .col       (col)
  );

  // Power-up is sent once and never forgotten
  a_powered_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.powered_up |=> stat.powered_up)
    else $error("powered_up dropped");

  // A lone nibble only goes out after power-up has been marked
  a_nibble_after_power: assert property (@(posedge clk) disable iff (rst)
    xfer.valid && !xfer.two_nibbles |-> stat.powered_up)
    else $error("lone nibble without power-up");

  // Inside an open frame the column stays on the display
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !stat.frame_done |-> (col < ColW'(COLUMNS)))
    else $error("column out of range in open frame");

endmodule

// File: test/clx_xfer_checker.sv
module clx_xfer_checker
  import clx_pkg::*;
#(
  parameter int COLUMNS = 24,
  parameter int ROWS    = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  clx_cmd_if   cmd,
  clx_xfer_if  xfer,
  output int   n_errors,
  output int   n_waiting,
  output int   n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       is_data;
    logic       two_nibbles;
    logic [3:0] first_nibble;
    logic [3:0] second_nibble;
    logic [7:0] bus_byte_a;
    logic [7:0] bus_byte_b;
    logic [7:0] bus_byte_c;
    logic [7:0] bus_byte_d;
    logic [7:0] bus_byte_e;
    logic [7:0] bus_byte_f;
    logic       last;
  } xfer_t;

  // Shadow of the display sequencer
  logic lamp;
  bit   display_up;
  int   row_idx;
  int   col_idx;
  bit   frame_closed;

  xfer_t item_xfers[$];
  xfer_t xfers_due[$];
  xfer_t want;
  xfer_t got;

  function automatic logic [7:0] expander_byte(logic [3:0] nib, logic rs);
    return {nib, lamp, 2'b00, rs};
  endfunction

  // Build one transfer; a lone init nibble leaves the second half zero
  function automatic void queue_xfer(logic rs, logic pair, logic [7:0] code);
    xfer_t x;
    logic [3:0] hi;
    logic [3:0] lo;
    if (item_xfers.size() >= MAX_RESULTS) return;
    hi = pair ? code[7:4] : code[3:0];
    lo = pair ? code[3:0] : 4'h0;
    x.is_data       = rs;
    x.two_nibbles   = pair;
    x.first_nibble  = hi;
    x.second_nibble = lo;
    x.bus_byte_a    = expander_byte(hi, rs);
    x.bus_byte_b    = expander_byte(hi, rs) | ENABLE_BIT;
    x.bus_byte_c    = expander_byte(hi, rs);
    x.bus_byte_d    = pair ? expander_byte(lo, rs) : 8'h00;
    x.bus_byte_e    = pair ? (expander_byte(lo, rs) | ENABLE_BIT) : 8'h00;
    x.bus_byte_f    = pair ? expander_byte(lo, rs) : 8'h00;
    x.last          = 1'b0;
    item_xfers.push_back(x);
  endfunction

  function automatic void queue_cursor();
    queue_xfer(1'b0, 1'b1, CURSOR_BASE + ROW_OFFSET * row_idx[7:0] + col_idx[7:0]);
  endfunction

  // Step one column; wrap to the next row or close the frame
  function automatic void step_column();
    col_idx++;
    if (col_idx >= COLUMNS) begin
      if (row_idx + 1 < ROWS) begin
        row_idx++;
        col_idx = 0;
        queue_cursor();
      end else begin
        frame_closed = 1'b1;
      end
    end
  endfunction

  function automatic void pad_current_row();
    int start_row;
    start_row = row_idx;
    while (!frame_closed && row_idx == start_row) begin
      queue_xfer(1'b1, 1'b1, SPACE_CHAR);
      step_column();
    end
  endfunction

  // Work out the transfers that one command item causes
  function automatic void predict_transfers(logic [1:0] kind, logic [7:0] code);
    item_xfers.delete();
    case (kind)
      KIND_BEGIN: begin
        if (!display_up) begin
          queue_xfer(1'b0, 1'b0, {4'h0, INIT_NIBBLE});
          queue_xfer(1'b0, 1'b1, FUNC_SET);
          display_up = 1'b1;
        end
        queue_xfer(1'b0, 1'b1, DISP_ON);
        queue_xfer(1'b0, 1'b1, ENTRY_MODE);
        queue_xfer(1'b0, 1'b1, SHIFT_CMD);
        row_idx      = 0;
        col_idx      = 0;
        frame_closed = 1'b0;
        queue_cursor();
      end
      KIND_BYTE: begin
        if (!frame_closed) begin
          if (code == BACKSLASH || code == NEWLINE || code == NUL_CHAR) begin
            pad_current_row();
          end else begin
            queue_xfer(1'b1, 1'b1, code);
            step_column();
          end
        end
      end
      KIND_END: begin
        while (!frame_closed) pad_current_row();
      end
      default: ;
    endcase
    if (item_xfers.size() > 0) item_xfers[item_xfers.size() - 1].last = 1'b1;
    foreach (item_xfers[i]) xfers_due.push_back(item_xfers[i]);
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      n_errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
    end
  endfunction

  // Track config, predict on each command item, compare each transfer
  always @(posedge clk) begin
    if (rst) begin
      lamp         = 1'b1;
      display_up   = 1'b0;
      row_idx      = 0;
      col_idx      = 0;
      frame_closed = 1'b1;
      xfers_due.delete();
      n_errors     = 0;
      n_checked    = 0;
    end else begin
      if (cfg_wr_en) lamp = cfg_wr_data;
      if (cmd.valid && cmd.ready) predict_transfers(cmd.kind, cmd.char_code);
      if (xfer.valid && xfer.ready) begin
        got = {xfer.is_data, xfer.two_nibbles, xfer.first_nibble, xfer.second_nibble,
               xfer.bus_byte_a, xfer.bus_byte_b, xfer.bus_byte_c, xfer.bus_byte_d,
               xfer.bus_byte_e, xfer.bus_byte_f, xfer.last};
        if (xfers_due.size() == 0) begin
          n_errors++;
          $display("%0t: transfer with none expected, got 0x%0h", $time, got);
        end else begin
          want = xfers_due.pop_front();
          n_checked++;
          check_field("is_data", int'(want.is_data), int'(got.is_data));
          check_field("two_nibbles", int'(want.two_nibbles), int'(got.two_nibbles));
          check_field("first_nibble", int'(want.first_nibble), int'(got.first_nibble));
          check_field("second_nibble", int'(want.second_nibble), int'(got.second_nibble));
          check_field("bus_byte_a", int'(want.bus_byte_a), int'(got.bus_byte_a));
          check_field("bus_byte_b", int'(want.bus_byte_b), int'(got.bus_byte_b));
          check_field("bus_byte_c", int'(want.bus_byte_c), int'(got.bus_byte_c));
          check_field("bus_byte_d", int'(want.bus_byte_d), int'(got.bus_byte_d));
          check_field("bus_byte_e", int'(want.bus_byte_e), int'(got.bus_byte_e));
          check_field("bus_byte_f", int'(want.bus_byte_f), int'(got.bus_byte_f));
          check_field("last", int'(want.last), int'(got.last));
        end
      end
    end
    n_waiting = xfers_due.size();
  end

endmodule

// File: test/char_lcd_4bit_expander_sequencer_core_tb.sv
module char_lcd_4bit_expander_sequencer_core_tb;
  import clx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         COLUMNS       = 24;
  localparam int         ROWS          = 2;
  localparam logic [1:0] KIND_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 60;
  localparam int         DRAIN_LIMIT   = 200000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int n_errors;
  int n_waiting;
  int n_checked;

  // Stimulus bookkeeping and knobs shared with the receiver
  int n_items;
  int n_frames;
  int n_noise;
  bit quiet;
  bit hold_request;

  clx_cmd_if  cmd_ch();
  clx_xfer_if xfer_ch();

  char_lcd_4bit_expander_sequencer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd_ch),
    .xfer       (xfer_ch)
  );

  clx_xfer_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) xfer_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd_ch),
    .xfer       (xfer_ch),
    .n_errors   (n_errors),
    .n_waiting  (n_waiting),
    .n_checked  (n_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bound the run
  initial begin
    #50_000_000;
    $display("timeout: %0d transfers still expected", n_waiting);
    $display("end of test: mismatches");
    $finish;
  end

  // Transfer receiver: random stalls, rare long ones, and a long hold on request
  initial begin
    int burst;
    int hold_left;
    int r;
    burst     = 0;
    hold_left = 0;
    xfer_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        xfer_ch.ready <= 1'b0;
        hold_left--;
      end else if (burst > 0) begin
        xfer_ch.ready <= 1'b0;
        burst--;
      end else if (quiet) begin
        xfer_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          xfer_ch.ready <= 1'b1;
        end else if (r < 97) begin
          xfer_ch.ready <= 1'b0;
          burst = $urandom_range(0, 2);
        end else begin
          xfer_ch.ready <= 1'b0;
          burst = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Offer one command item and hold it until taken
  task automatic send_item(logic [1:0] kind, logic [7:0] code);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.kind      <= kind;
    cmd_ch.char_code <= code;
    do @(posedge clk); while (!cmd_ch.ready);
    n_items++;
  endtask

  // Drop valid and wait until every expected transfer is out
  task automatic drain_out();
    int spins;
    spins = 0;
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (n_waiting != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_backlight(logic value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return BACKSLASH;
    if (r < 6) return NEWLINE;
    if (r < 8) return NUL_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // One frame: begin, random text, usually an end
  task automatic send_frame(int n_chars, bit close_it);
    send_item(KIND_BEGIN, 8'($urandom_range(0, 255)));
    repeat (n_chars) send_item(KIND_BYTE, pick_char());
    if (close_it) send_item(KIND_END, 8'($urandom_range(0, 255)));
    n_frames++;
  endtask

  // Mostly well-formed frames, some stray commands in between
  task automatic random_phase(int budget);
    int stop_at;
    int n_chars;
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 52) : $urandom_range(0, 30);
        send_frame(n_chars, $urandom_range(0, 99) < 80);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          n_noise++;
        end
      end
    end
  endtask

  initial begin
    n_items      = 0;
    n_frames     = 0;
    n_noise      = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.kind      = KIND_BEGIN;
    cmd_ch.char_code = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: backlight off first
    write_backlight(1'b0);
    // Stray commands before any frame, then the power-up begin
    send_item(KIND_BYTE, 8'h41);
    send_item(KIND_END, 8'h00);
    send_item(KIND_SPARE, 8'hFF);
    send_item(KIND_BEGIN, 8'h00);
    // Character extremes, row pad, then frame close by newline
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'h7F);
    send_item(KIND_BYTE, 8'h80);
    send_item(KIND_BYTE, BACKSLASH);
    send_item(KIND_BYTE, 8'h78);
    send_item(KIND_BYTE, NEWLINE);
    // Closed frame ignores bytes and end
    send_item(KIND_BYTE, 8'h71);
    send_item(KIND_END, 8'hFF);
    // Second begin skips power-up
    send_item(KIND_BEGIN, 8'hFF);
    send_item(KIND_BYTE, NUL_CHAR);
    send_item(KIND_BYTE, 8'h55);
    send_item(KIND_BYTE, 8'hAA);
    send_item(KIND_END, 8'h00);
    // Empty frame: end pads both rows
    send_item(KIND_BEGIN, 8'h55);
    send_item(KIND_SPARE, 8'h00);
    send_item(KIND_END, 8'hAA);
    // Begin in mid-frame restarts it
    send_item(KIND_BEGIN, 8'h00);
    send_item(KIND_BYTE, 8'h6D);
    send_item(KIND_BEGIN, 8'h00);
    send_item(KIND_END, 8'h00);
    drain_out();

    // Random, normal idling, backlight on
    write_backlight(1'b1);
    random_phase(140);
    drain_out();

    // Random with no idling; receiver holds off while frames keep coming
    write_backlight(1'b0);
    quiet = 1'b1;
    random_phase(50);
    hold_request = 1'b1;
    send_frame(30, 1'b1);
    random_phase(50);
    quiet = 1'b0;
    drain_out();

    // Random, back to idling, backlight on
    write_backlight(1'b1);
    random_phase(140);
    drain_out();

    $display("covered %0d command items in %0d frames plus %0d stray commands",
             n_items, n_frames, n_noise);
    $display("checked %0d transfers across both backlight settings", n_checked);
    if (n_errors == 0 && n_waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d transfers never seen", n_errors, n_waiting);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/clx_pkg.sv
hdl/clx_if.sv
hdl/clx_front.sv
hdl/clx_fifo.sv
hdl/clx_back.sv
hdl/char_lcd_4bit_expander_sequencer_core.sv
test/clx_xfer_checker.sv
test/char_lcd_4bit_expander_sequencer_core_tb.sv
